@@ hw/rtl/lse_pkg.sv @@
`default_nettype none

package lse_pkg;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_MODE       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEADER_LEN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MARKER     = 2'd2;
	localparam int unsigned CFG_DATA_W = 16;

	// Register reset values.
	localparam logic        MODE_RESET       = 1'b0;
	localparam logic [15:0] HEADER_LEN_RESET = 16'd54;
	localparam logic [7:0]  MARKER_RESET     = 8'd178;

	localparam logic MODE_EMBED   = 1'b0;
	localparam logic MODE_EXTRACT = 1'b1;

	// Stream phase codes.
	localparam logic [2:0] PH_HEADER = 3'd0;
	localparam logic [2:0] PH_START  = 3'd1;
	localparam logic [2:0] PH_BODY   = 3'd2;
	localparam logic [2:0] PH_END    = 3'd3;
	localparam logic [2:0] PH_DONE   = 3'd4;

	typedef struct packed {
		logic        mode;
		logic [15:0] header_length;
		logic [7:0]  marker;
	} cfg_t;

	typedef struct packed {
		logic [15:0] position_count;
		logic [2:0]  phase;
		logic [2:0]  bit_index;
		logic [7:0]  shift_reg;
		logic        marked_flag;
	} stream_state_t;

	typedef struct packed {
		logic       first_byte;
		logic [7:0] image_byte;
		logic [7:0] message_byte;
		logic       message_end;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       message_taken;
		logic       char_valid;
		logic [7:0] char_out;
		logic       marked;
		logic       finished;
	} out_beat_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_beat_t;

endpackage

`default_nettype wire

@@ hw/rtl/lse_if.sv @@
`default_nettype none

interface lse_in_if;
	import lse_pkg::*;
	logic     valid;
	logic     ready;
	in_beat_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface lse_out_if;
	import lse_pkg::*;
	logic      valid;
	logic      ready;
	out_beat_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface lse_cfg_if;
	import lse_pkg::*;
	logic      valid;
	logic      ready;
	cfg_beat_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/lse_step.sv @@
`default_nettype none

module lse_step import lse_pkg::*; (
	input  wire cfg_t          cfg,
	input  wire stream_state_t state,
	input  wire in_beat_t      beat,
	output stream_state_t      next_state,
	output out_beat_t          result
);

	stream_state_t st;
	stream_state_t hd;
	logic [7:0]    ob;
	logic          taken;
	logic          cvalid;
	logic [7:0]    cout;
	logic          fin;
	logic [7:0]    gathered;

	always_comb begin
		// A first byte restarts the stream before it is handled.
		st = state;
		if (beat.first_byte) begin
			st = '0;
			st.phase = PH_HEADER;
		end

		hd = st;
		if (st.phase == PH_HEADER) begin
			if (st.position_count < cfg.header_length) begin
				hd.position_count = st.position_count + 16'd1;
			end else begin
				hd.phase = PH_START;
				hd.bit_index = 3'd0;
				hd.shift_reg = 8'd0;
			end
		end

		next_state = hd;
		ob = beat.image_byte;
		taken = 1'b0;
		cvalid = 1'b0;
		cout = 8'd0;
		fin = 1'b0;
		gathered = {beat.image_byte[0], hd.shift_reg[7:1]};

		if (hd.phase != PH_HEADER) begin
			if (cfg.mode == MODE_EMBED) begin
				// The end of the message is only looked at when a group starts.
				if (hd.phase == PH_BODY && hd.bit_index == 3'd0) begin
					if (beat.message_end) begin
						next_state.phase = PH_END;
					end else begin
						next_state.shift_reg = beat.message_byte;
						taken = 1'b1;
					end
				end
				case (next_state.phase)
					PH_START, PH_END: begin
						ob = {beat.image_byte[7:1], cfg.marker[hd.bit_index]};
						if (hd.bit_index == 3'd7) begin
							if (next_state.phase == PH_START) begin
								next_state.phase = PH_BODY;
							end else begin
								next_state.phase = PH_DONE;
								fin = 1'b1;
							end
						end
						next_state.bit_index = hd.bit_index + 3'd1;
					end
					PH_BODY: begin
						ob = {beat.image_byte[7:1], next_state.shift_reg[hd.bit_index]};
						next_state.bit_index = hd.bit_index + 3'd1;
					end
					default: begin
						fin = 1'b1;
					end
				endcase
			end else begin
				case (hd.phase)
					PH_START, PH_BODY: begin
						next_state.shift_reg = gathered;
						if (hd.bit_index == 3'd7) begin
							if (hd.phase == PH_START) begin
								if (gathered == cfg.marker) begin
									next_state.marked_flag = 1'b1;
									next_state.phase = PH_BODY;
								end else begin
									next_state.phase = PH_DONE;
									fin = 1'b1;
								end
							end else if (gathered == cfg.marker) begin
								next_state.phase = PH_DONE;
								fin = 1'b1;
							end else begin
								cvalid = 1'b1;
								cout = gathered;
							end
						end
						next_state.bit_index = hd.bit_index + 3'd1;
					end
					default: begin
						fin = 1'b1;
					end
				endcase
			end
		end

		result.out_byte = ob;
		result.message_taken = taken;
		result.char_valid = cvalid;
		result.char_out = cout;
		result.marked = (cfg.mode == MODE_EXTRACT) ? next_state.marked_flag : 1'b0;
		result.finished = fin;
	end

endmodule

`default_nettype wire

@@ hw/rtl/lsb_stego_embed_extract_top.sv @@
// LSB steganography embed and extract, one image byte per beat.
//
// Channels: image carries one image byte per beat together with first_byte,
// the pending message byte and message_end. result returns exactly one beat
// for every image beat: the output byte, message_taken, the finished flag and,
// in extract mode, a completed character with the marked flag. cfg writes the
// mode, header length and marker registers; it is always ready and should
// only be written while no result is outstanding.
// The result beat is registered and appears in the cycle after its image beat is accepted.
// Throughput is one beat per cycle, set by the single output register: a new
// image beat is taken whenever that register is empty or is being read.
// When the receiver stalls, the result holds and image ready drops until it
// is taken.
// Reset restores mode embed, header length 54 and marker 178, and restarts
// the stream state; a beat with first_byte set restarts it as well.
`default_nettype none

module lsb_stego_embed_extract_top import lse_pkg::*; (
	input wire      clk,
	input wire      arst_n,
	lse_in_if.sink  image,
	lse_out_if.source result,
	lse_cfg_if.sink cfg
);

	cfg_t          cfg_q;
	stream_state_t state_q;
	stream_state_t state_next;
	out_beat_t     step_result;
	logic          out_valid_q;
	out_beat_t     out_data_q;
	logic          accept;

	assign cfg.ready = 1'b1;
	assign image.ready = !out_valid_q || result.ready;
	assign accept = image.valid && image.ready;
	assign result.valid = out_valid_q;
	assign result.data = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode <= MODE_RESET;
			cfg_q.header_length <= HEADER_LEN_RESET;
			cfg_q.marker <= MARKER_RESET;
		end else if (cfg.valid) begin
			case (cfg.data.index)
				REG_MODE:       cfg_q.mode <= cfg.data.data[0];
				REG_HEADER_LEN: cfg_q.header_length <= cfg.data.data;
				REG_MARKER:     cfg_q.marker <= cfg.data.data[7:0];
				default: begin
				end
			endcase
		end
	end

	lse_step u_step (
		.cfg        (cfg_q),
		.state      (state_q),
		.beat       (image.data),
		.next_state (state_next),
		.result     (step_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			out_valid_q <= 1'b0;
		end else if (accept) begin
			state_q <= state_next;
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= step_result;
		end
	end

`ifndef SYNTHESIS
	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q)
		else $error("accepted image beat produced no result");

	a_char_only_extract: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q.char_valid) |-> (cfg_q.mode == MODE_EXTRACT))
		else $error("character emitted outside extract mode");

	a_taken_only_embed: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q.message_taken) |->
			(!out_data_q.char_valid && !out_data_q.marked))
		else $error("message byte taken on an extract result");

	a_char_zero_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_data_q.char_valid) |-> (out_data_q.char_out == 8'd0))
		else $error("character data without char_valid");
`endif

endmodule

`default_nettype wire

@@ sim/tb_lsb_stego_embed_extract_top.sv @@
`default_nettype none

module tb_lsb_stego_embed_extract_top;
	timeunit 1ns;
	timeprecision 1ps;

	import lse_pkg::*;

	localparam int CLK_PERIOD = 10;
	localparam int RESET_CYCLES = 6;
	localparam int CYCLE_LIMIT = 600000;
	localparam int HOLD_CYCLES = 250;
	localparam int RANDOM_BEATS = 1330;

	typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t            kind;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic [15:0]          reg_val;
		in_beat_t             beat;
		logic                 typed;
		out_beat_t            want;
	} dir_row_t;

	// Directed rows: header pass-through after reset, an empty-header embed
	// with an immediate message end, then an unmarked image in extract mode.
	localparam int DIR_ROWS = 30;
	localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
		'{ROW_BEAT, REG_MODE, 16'd0, {1'b1, 8'hFF, 8'h00, 1'b0}, 1'b1, {8'hFF, 12'd0}},
		'{ROW_BEAT, REG_MODE, 16'd0, {1'b0, 8'h00, 8'hFF, 1'b1}, 1'b1, {8'h00, 12'd0}},
		'{ROW_CFG, REG_HEADER_LEN, 16'd0, '0, 1'b0, '0},
		'{ROW_CFG, REG_MARKER, 16'h00FF, '0, 1'b0, '0},
		'{ROW_BEAT, REG_MODE, 16'd0, {1'b1, 8'h00, 8'hA5, 1'b0}, 1'b1, {8'h01, 12'd0}},
		'{ROW_BEAT, REG_MODE, 16'd0, {1'b0, 8'hFF, 8'h00, 1'b0}, 1'b0, '0},
		'{ROW_BEAT, REG_MODE, 16'd0, {1'b0, 8'h00, 8'hFF, 1'b0}, 1'b0, '0},
		'{ROW_BEAT, REG_MODE, 16'd0, {1'b0, 8'hFF, 8'h3C, 1'b1}, 1'b0, '0},
		'{ROW_BEAT, REG_MODE, 16'd0, {1'b0, 8'h00, 8'hC3, 1'b0}, 1'b0, '0},
		'{ROW_BEAT, REG_MODE, 16'd0, {1'b0, 8'h7E, 8'h01, 1'b0}, 1'b0, '0},
		'{ROW_BEAT, REG_MODE, 16'd0, {1'b0, 8'h81, 8'h80, 1'b1}, 1'b0, '0},
		'{ROW_BEAT, REG_MODE, 16'd0, {1'b0, 8'hFF, 8'h55, 1'b0}, 1'b0, '0},
		'{ROW_BEAT, REG_MODE, 16'd0, {1'b0, 8'hFE, 8'h5A, 1'b1}, 1'b0, '0},
		'{ROW_BEAT, REG_MODE, 16'd0, {1'b0, 8'h00, 8'hAA, 1'b0}, 1'b0, '0},
		'{ROW_BEAT, REG_MODE, 16'd0, {1'b0, 8'hFF, 8'h00, 1'b1}, 1'b0, '0},
		'{ROW_BEAT, REG_MODE, 16'd0, {1'b0, 8'h55, 8'hFF, 1'b0}, 1'b0, '0},
		'{ROW_BEAT, REG_MODE, 16'd0, {1'b0, 8'hAA, 8'h12, 1'b1}, 1'b0, '0},
		'{ROW_BEAT, REG_MODE, 16'd0, {1'b0, 8'h01, 8'h34, 1'b0}, 1'b0, '0},
		'{ROW_BEAT, REG_MODE, 16'd0, {1'b0, 8'hFE, 8'h56, 1'b1}, 1'b0, '0},
		'{ROW_BEAT, REG_MODE, 16'd0, {1'b0, 8'h80, 8'h78, 1'b0}, 1'b1,
			{8'h81, 11'd0, 1'b1}},
		'{ROW_CFG, REG_MODE, 16'd1, '0, 1'b0, '0},
		'{ROW_CFG, REG_MARKER, 16'h0000, '0, 1'b0, '0},
		'{ROW_BEAT, REG_MODE, 16'd0, {1'b1, 8'hFF, 8'h00, 1'b0}, 1'b0, '0},
		'{ROW_BEAT, REG_MODE, 16'd0, {1'b0, 8'h01, 8'hFF, 1'b1}, 1'b0, '0},
		'{ROW_BEAT, REG_MODE, 16'd0, {1'b0, 8'h03, 8'h00, 1'b0}, 1'b0, '0},
		'{ROW_BEAT, REG_MODE, 16'd0, {1'b0, 8'hFF, 8'hFF, 1'b1}, 1'b0, '0},
		'{ROW_BEAT, REG_MODE, 16'd0, {1'b0, 8'h7F, 8'h0F, 1'b0}, 1'b0, '0},
		'{ROW_BEAT, REG_MODE, 16'd0, {1'b0, 8'h81, 8'hF0, 1'b1}, 1'b0, '0},
		'{ROW_BEAT, REG_MODE, 16'd0, {1'b0, 8'hC1, 8'h99, 1'b0}, 1'b0, '0},
		'{ROW_BEAT, REG_MODE, 16'd0, {1'b0, 8'h01, 8'h66, 1'b1}, 1'b1,
			{8'h01, 11'd0, 1'b1}}
	};

	logic clk;
	logic arst_n;

	lse_in_if  image_if ();
	lse_out_if result_if ();
	lse_cfg_if cfg_if ();

	lsb_stego_embed_extract_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.image  (image_if),
		.result (result_if),
		.cfg    (cfg_if)
	);

	// Predictor copy of the registers and the stream state.
	logic        cfg_mode;
	logic [15:0] cfg_hdr_len;
	logic [7:0]  cfg_marker;
	logic [15:0] st_pos;
	logic [2:0]  st_phase;
	logic [2:0]  st_bit;
	logic [7:0]  st_shift;
	logic        st_marked;

	out_beat_t   awaited_out_beats [$];

	int unsigned beats_in;
	int unsigned beats_out;
	int unsigned images_sent;
	int unsigned errors;
	int unsigned taken_seen;
	int unsigned chars_seen;
	int unsigned finished_seen;
	int unsigned cycles;
	int unsigned tx_calm;
	int unsigned rx_calm;
	bit          hold_req;
	bit          hold_off;

	initial clk = 1'b0;
	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic int unsigned next_gap(inout int unsigned calm);
		int unsigned r;
		if (calm != 0) begin
			calm = calm - 1;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2)
			calm = $urandom_range(20, 80);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic void restart_stream();
		st_pos = 16'd0;
		st_phase = PH_HEADER;
		st_bit = 3'd0;
		st_shift = 8'd0;
		st_marked = 1'b0;
	endfunction

	function automatic out_beat_t stego_predict(input in_beat_t b);
		out_beat_t o;
		o = '0;
		o.out_byte = b.image_byte;
		if (b.first_byte)
			restart_stream();
		if (st_phase == PH_HEADER) begin
			if (st_pos < cfg_hdr_len) begin
				st_pos = st_pos + 16'd1;
			end else begin
				st_phase = PH_START;
				st_bit = 3'd0;
				st_shift = 8'd0;
			end
		end
		if (st_phase != PH_HEADER) begin
			if (cfg_mode == MODE_EMBED) begin
				// A message byte is latched only where a body group starts.
				if (st_phase == PH_BODY && st_bit == 3'd0) begin
					if (b.message_end) begin
						st_phase = PH_END;
					end else begin
						st_shift = b.message_byte;
						o.message_taken = 1'b1;
					end
				end
				if (st_phase == PH_START || st_phase == PH_END) begin
					o.out_byte[0] = cfg_marker[st_bit];
					if (st_bit == 3'd7) begin
						if (st_phase == PH_START) begin
							st_phase = PH_BODY;
						end else begin
							st_phase = PH_DONE;
							o.finished = 1'b1;
						end
					end
					st_bit = st_bit + 3'd1;
				end else if (st_phase == PH_BODY) begin
					o.out_byte[0] = st_shift[st_bit];
					st_bit = st_bit + 3'd1;
				end else begin
					o.finished = 1'b1;
				end
			end else if (st_phase == PH_START || st_phase == PH_BODY) begin
				st_shift = {b.image_byte[0], st_shift[7:1]};
				if (st_bit == 3'd7) begin
					if (st_shift == cfg_marker) begin
						if (st_phase == PH_START) begin
							st_marked = 1'b1;
							st_phase = PH_BODY;
						end else begin
							st_phase = PH_DONE;
							o.finished = 1'b1;
						end
					end else if (st_phase == PH_START) begin
						st_phase = PH_DONE;
						o.finished = 1'b1;
					end else begin
						o.char_valid = 1'b1;
						o.char_out = st_shift;
					end
				end
				st_bit = st_bit + 3'd1;
			end else begin
				// In extract mode the end-frame phase reads as done.
				o.finished = 1'b1;
			end
		end
		o.marked = (cfg_mode == MODE_EXTRACT) && st_marked;
		return o;
	endfunction

	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		errors++;
		if (errors <= 40)
			$display("[%0t] result beat %0d: %s got 'h%0h, want 'h%0h",
				$realtime, beats_out, what, got, want);
	endtask

	task automatic check_result(input out_beat_t got);
		out_beat_t want;
		if (awaited_out_beats.size() == 0) begin
			report_mismatch("unexpected beat, out_byte", got.out_byte, 8'h00);
		end else begin
			want = awaited_out_beats.pop_front();
			if (got.out_byte !== want.out_byte)
				report_mismatch("out_byte", got.out_byte, want.out_byte);
			if (got.message_taken !== want.message_taken)
				report_mismatch("message_taken", {7'd0, got.message_taken},
					{7'd0, want.message_taken});
			if (got.char_valid !== want.char_valid)
				report_mismatch("char_valid", {7'd0, got.char_valid},
					{7'd0, want.char_valid});
			if (got.char_out !== want.char_out)
				report_mismatch("char_out", got.char_out, want.char_out);
			if (got.marked !== want.marked)
				report_mismatch("marked", {7'd0, got.marked}, {7'd0, want.marked});
			if (got.finished !== want.finished)
				report_mismatch("finished", {7'd0, got.finished},
					{7'd0, want.finished});
		end
		if (got.message_taken === 1'b1)
			taken_seen++;
		if (got.char_valid === 1'b1)
			chars_seen++;
		if (got.finished === 1'b1)
			finished_seen++;
		beats_out++;
	endtask

	always @(posedge clk) begin
		if (arst_n && result_if.valid && result_if.ready)
			check_result(result_if.data);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("[%0t] timeout with %0d results outstanding", $realtime,
				awaited_out_beats.size());
			$display("tb_lsb_stego_embed_extract_top: done, errors");
			$finish;
		end
	end

	// Result side: random stalls, plus one long hold-off while the image side
	// keeps offering beats.
	initial begin
		int unsigned stall;
		stall = 0;
		result_if.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off) begin
				result_if.ready <= 1'b0;
			end else if (stall != 0) begin
				stall = stall - 1;
				result_if.ready <= 1'b0;
			end else begin
				result_if.ready <= 1'b1;
				stall = next_gap(rx_calm);
			end
		end
	end

	initial begin
		hold_off = 1'b0;
		wait (hold_req);
		hold_off = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off = 1'b0;
	end

	task automatic send_beat(input in_beat_t b, input logic typed,
			input out_beat_t typed_want, output out_beat_t pred);
		int unsigned gap;
		gap = next_gap(tx_calm);
		@(negedge clk);
		if (gap != 0) begin
			image_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		image_if.valid <= 1'b1;
		image_if.data <= b;
		@(posedge clk);
		while (!image_if.ready)
			@(posedge clk);
		pred = stego_predict(b);
		awaited_out_beats.push_back(typed ? typed_want : pred);
		beats_in++;
	endtask

	task automatic drain();
		@(negedge clk);
		image_if.valid <= 1'b0;
		while (awaited_out_beats.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		drain();
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.data <= {idx, val};
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		case (idx)
			REG_MODE: cfg_mode = val[0];
			REG_HEADER_LEN: cfg_hdr_len = val;
			REG_MARKER: cfg_marker = val[7:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	initial begin
		logic [7:0]  frame [$];
		logic [7:0]  start_char;
		in_beat_t    b;
		out_beat_t   p;
		int unsigned mlen, total, hb, flip_at, shrink_at, mi, r;
		bit          noise, unmarked, hold_img;

		arst_n = 1'b0;
		image_if.valid <= 1'b0;
		image_if.data <= '0;
		cfg_if.valid <= 1'b0;
		cfg_if.data <= '0;
		cfg_mode = MODE_RESET;
		cfg_hdr_len = HEADER_LEN_RESET;
		cfg_marker = MARKER_RESET;
		restart_stream();
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int row = 0; row < DIR_ROWS; row++) begin
			if (DIR_TABLE[row].kind == ROW_CFG)
				write_reg(DIR_TABLE[row].reg_idx, DIR_TABLE[row].reg_val);
			else
				send_beat(DIR_TABLE[row].beat, DIR_TABLE[row].typed, DIR_TABLE[row].want, p);
		end

		// Random images: mostly well-formed frames, some unmarked, cut short
		// or pure noise, with register changes between and inside images.
		while (beats_in < RANDOM_BEATS) begin
			hold_img = !hold_req && beats_in >= 350;
			if (images_sent == 3) begin
				write_reg(REG_HEADER_LEN, 16'hFFFF);
			end else if (!hold_img && $urandom_range(0, 1) == 0) begin
				if ($urandom_range(0, 1) == 0)
					write_reg(REG_MODE, 16'($urandom_range(0, 1)));
				if ($urandom_range(0, 1) == 0) begin
					r = $urandom_range(0, 9);
					if (r == 0)
						write_reg(REG_HEADER_LEN, 16'd0);
					else if (r < 8)
						write_reg(REG_HEADER_LEN, 16'($urandom_range(1, 8)));
					else
						write_reg(REG_HEADER_LEN, 16'($urandom_range(9, 60)));
				end
				if ($urandom_range(0, 1) == 0) begin
					r = $urandom_range(0, 7);
					if (r == 0)
						write_reg(REG_MARKER, 16'h0000);
					else if (r == 1)
						write_reg(REG_MARKER, 16'h00FF);
					else
						write_reg(REG_MARKER, {8'd0, 8'($urandom)});
				end
			end
			if (hold_img)
				hold_req = 1'b1;

			noise = !hold_img && $urandom_range(0, 9) == 0;
			unmarked = !hold_img && $urandom_range(0, 6) == 0;
			mlen = hold_img ? 6 : $urandom_range(0, 4);

			// Frame bytes: start marker (or a near miss), message, end marker.
			start_char = unmarked ? cfg_marker ^ (8'h01 << $urandom_range(0, 7)) : cfg_marker;
			frame.delete();
			frame.push_back(start_char);
			repeat (mlen) frame.push_back(8'($urandom));
			frame.push_back(cfg_marker);
			if (mlen != 0 && $urandom_range(0, 7) == 0)
				frame[$urandom_range(1, mlen)] = cfg_marker;

			shrink_at = 0;
			if (cfg_hdr_len > 16'd1000) begin
				shrink_at = $urandom_range(1, 8);
				hb = shrink_at;
			end else begin
				hb = 32'(cfg_hdr_len);
			end
			total = hb + 8 * frame.size() + $urandom_range(0, 6);
			if (!hold_img && $urandom_range(0, 9) == 0)
				total = $urandom_range(1, total);
			if (noise)
				total = $urandom_range(1, 30);
			flip_at = 0;
			if (!hold_img && $urandom_range(0, 5) == 0)
				flip_at = $urandom_range(1, total);

			mi = 0;
			for (int unsigned i = 0; i < total; i++) begin
				// Lowering a huge header length mid-image ends the header here.
				if (shrink_at != 0 && i == shrink_at)
					write_reg(REG_HEADER_LEN, 16'($urandom_range(0, shrink_at)));
				if (flip_at != 0 && i == flip_at)
					write_reg(REG_MODE, {15'd0, ~cfg_mode});
				b.first_byte = (i == 0);
				b.image_byte = 8'($urandom);
				if (i >= hb && i - hb < 8 * frame.size())
					b.image_byte[0] = frame[(i - hb) / 8][(i - hb) % 8];
				b.message_byte = (mi < mlen) ? frame[mi + 1] : 8'($urandom);
				b.message_end = (mi >= mlen);
				if (noise) begin
					b.first_byte = (i == 0) || $urandom_range(0, 19) == 0;
					b.message_byte = 8'($urandom);
					b.message_end = 1'($urandom);
				end
				send_beat(b, 1'b0, '0, p);
				if (p.message_taken)
					mi++;
			end
			if (images_sent % 37 == 36)
				drain();
			images_sent++;
		end

		drain();
		repeat (8) @(posedge clk);
		$display("Covered %0d image beats over %0d random images, %0d result beats checked.",
			beats_in, images_sent, beats_out);
		$display("Saw %0d message bytes taken, %0d characters extracted, %0d finished beats.",
			taken_seen, chars_seen, finished_seen);
		if (errors == 0)
			$display("tb_lsb_stego_embed_extract_top: done, clean");
		else
			$display("tb_lsb_stego_embed_extract_top: done, errors");
		$finish;
	end

endmodule

`default_nettype wire

@@ lsb_stego_embed_extract_top.f @@
hw/rtl/lse_pkg.sv
hw/rtl/lse_if.sv
hw/rtl/lse_step.sv
hw/rtl/lsb_stego_embed_extract_top.sv
sim/tb_lsb_stego_embed_extract_top.sv
